// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; mhkv_back is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hw/rtl/mhkv_pkg.sv =====
// Package with constants and types of the hash key-value table.
package mhkv_pkg;
	localparam int NUM_BUCKETS = 16;
	localparam int SLOTS_PER_BUCKET = 8;
	localparam int TOTAL_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int IW = $clog2(TOTAL_SLOTS + 1);
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED = 3'd1,
		ST_REMOVED = 3'd2,
		ST_FOUND = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_BUCKET_FULL = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef struct packed {
		req_t req;
		logic [BW-1:0] bucket;
		logic [31:0] key;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage

// ===== hw/rtl/mhkv_front.sv =====
// Front part: takes requests, finds the bucket and pushes commands.
module mhkv_front (
	input logic s_tvalid,
	output logic s_tready,
	input logic [1:0] s_tuser,
	input logic [63:0] s_tdata,
	output logic push,
	output mhkv_pkg::cmd_t cmd,
	input mhkv_pkg::qstat_t qstat
);
	logic [31:0] key_w;
	assign key_w = s_tdata[31:0];
	assign s_tready = !qstat.full;
	assign push = s_tvalid && s_tready;
	always_comb begin
		cmd.req = mhkv_pkg::req_t'(s_tuser);
		cmd.key = key_w;
		cmd.value = s_tdata[63:32];
		cmd.bucket = mhkv_pkg::BW'(key_w % mhkv_pkg::NUM_BUCKETS);
	end
endmodule

// ===== hw/rtl/mhkv_queue.sv =====
// Short command queue between the front and back parts.
module mhkv_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mhkv_pkg::cmd_t din,
	input logic pop,
	output mhkv_pkg::cmd_t dout,
	output mhkv_pkg::qstat_t qstat
);
	mhkv_pkg::cmd_t mem_q [mhkv_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign qstat.full = cnt_q == 2'(mhkv_pkg::QDEPTH);
	assign qstat.empty = cnt_q == 2'd0;
	assign dout = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hw/rtl/mhkv_back.sv =====
// Back part: walks a bucket's slots one per cycle, answers searches and updates the table.
`include "assert_macros.svh"
module mhkv_back (
	input logic clk,
	input logic arst_n,
	input mhkv_pkg::cmd_t cmd,
	input mhkv_pkg::qstat_t qstat,
	output logic pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [2:0] m_tuser,
	output logic [31:0] m_tdata
);
	typedef enum logic [1:0] {IDLE, WALK, DONE} state_t;
	localparam int TW = $clog2(mhkv_pkg::TOTAL_SLOTS);
	state_t state_q;
	logic [mhkv_pkg::TOTAL_SLOTS-1:0] valid_q;
	logic [31:0] key_mem [mhkv_pkg::TOTAL_SLOTS];
	logic [31:0] val_mem [mhkv_pkg::TOTAL_SLOTS];
	logic [31:0] rkey_q, rval_q;
	logic rvalid_q, rd_pend_q;
	logic [mhkv_pkg::SW:0] slot_q;
	logic [mhkv_pkg::SW-1:0] rslot_q, free_q;
	logic free_ok_q;
	logic [TW-1:0] raddr, waddr;
	logic we;
	logic [31:0] wkey, wval;
	logic hit;
	mhkv_pkg::cmd_t c_q;

	function automatic logic [TW-1:0] addr_of(logic [mhkv_pkg::BW-1:0] b,
			logic [mhkv_pkg::SW-1:0] s);
		return TW'(32'(b) * mhkv_pkg::SLOTS_PER_BUCKET + 32'(s));
	endfunction

	assign raddr = addr_of(c_q.bucket, slot_q[mhkv_pkg::SW-1:0]);
	assign hit = rd_pend_q && rvalid_q && rkey_q == c_q.key;
	assign pop = state_q == IDLE && !qstat.empty && !m_tvalid;

	always_ff @(posedge clk) begin
		rkey_q <= key_mem[raddr];
		rval_q <= val_mem[raddr];
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = addr_of(c_q.bucket, rslot_q);
		wkey = c_q.key;
		wval = c_q.value;
		if (state_q == WALK && c_q.req == mhkv_pkg::REQ_INSERT) begin
			if (hit) we = 1'b1;
			else if (!rd_pend_q || slot_q[mhkv_pkg::SW]) begin
				we = 1'b0;
			end
			if (!hit && slot_q[mhkv_pkg::SW] && !rd_pend_q && free_ok_q) begin
				we = 1'b1;
				waddr = addr_of(c_q.bucket, free_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			valid_q <= '0;
			m_tvalid <= 1'b0;
			m_tuser <= 3'd0;
			m_tdata <= 32'd0;
			slot_q <= '0;
			rslot_q <= '0;
			free_q <= '0;
			free_ok_q <= 1'b0;
			rvalid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			c_q <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (pop) begin
						c_q <= cmd;
						slot_q <= '0;
						rd_pend_q <= 1'b0;
						free_ok_q <= 1'b0;
						state_q <= WALK;
					end
				end
				WALK: begin
					if (c_q.req == mhkv_pkg::REQ_CLEAR) begin
						valid_q <= '0;
						m_tuser <= mhkv_pkg::ST_CLEARED;
						m_tdata <= 32'd0;
						state_q <= DONE;
					end else if (hit) begin
						m_tdata <= 32'd0;
						case (c_q.req)
							mhkv_pkg::REQ_INSERT: m_tuser <= mhkv_pkg::ST_UPDATED;
							mhkv_pkg::REQ_REMOVE: begin
								m_tuser <= mhkv_pkg::ST_REMOVED;
								valid_q[addr_of(c_q.bucket, rslot_q)] <= 1'b0;
							end
							default: begin
								m_tuser <= mhkv_pkg::ST_FOUND;
								m_tdata <= rval_q;
							end
						endcase
						state_q <= DONE;
					end else if (slot_q[mhkv_pkg::SW] && !rd_pend_q) begin
						m_tdata <= 32'd0;
						if (c_q.req != mhkv_pkg::REQ_INSERT) m_tuser <= mhkv_pkg::ST_NOT_FOUND;
						else if (free_ok_q) begin
							m_tuser <= mhkv_pkg::ST_INSERTED;
							valid_q[addr_of(c_q.bucket, free_q)] <= 1'b1;
						end else m_tuser <= mhkv_pkg::ST_BUCKET_FULL;
						state_q <= DONE;
					end else begin
						if (rd_pend_q && !rvalid_q && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= rslot_q;
						end
						if (slot_q[mhkv_pkg::SW]) rd_pend_q <= 1'b0;
						else begin
							rd_pend_q <= 1'b1;
							rslot_q <= slot_q[mhkv_pkg::SW-1:0];
							rvalid_q <= valid_q[raddr];
							slot_q <= (32'(slot_q) + 1 == mhkv_pkg::SLOTS_PER_BUCKET) ?
								{1'b1, {mhkv_pkg::SW{1'b0}}} : slot_q + 1'b1;
						end
					end
				end
				DONE: begin
					m_tvalid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_pop_idle, clk, arst_n, !pop || !m_tvalid, "pop while result pending")
	`ASSERT_NEXT(a_done_out, clk, arst_n, state_q == DONE, m_tvalid, "result not shown after done")
	`ASSERT_IMPL(a_status_rng, clk, arst_n, !m_tvalid || m_tuser != 3'd7, "bad status")
	`ASSERT_IMPL(a_found_zero, clk, arst_n,
		!m_tvalid || m_tuser == mhkv_pkg::ST_FOUND || m_tdata == 32'd0, "nonzero value")
endmodule

// ===== hw/rtl/modulo_hash_key_value_table.sv =====
// Top level of the modulo hash key-value table.
// The back part walks the bucket's slots in turn; a hit ends the walk early.
// A clear does not walk the slots. The back part takes a new request only when idle
// and its last result has been accepted.
// The front part accepts while the two-entry command queue has room.
// Reset clears all slot valid bits at once; keys and values need no reset.
module modulo_hash_key_value_table (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [63:0] s_tdata, // key, value
	input logic [1:0] s_tuser, // req_type
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // found_value
	output logic [2:0] m_tuser // status
);
	logic push, pop;
	mhkv_pkg::cmd_t cmd_in, cmd_out;
	mhkv_pkg::qstat_t qstat;

	mhkv_front u_front (.s_tvalid, .s_tready, .s_tuser, .s_tdata,
		.push, .cmd(cmd_in), .qstat);
	mhkv_queue u_queue (.clk, .arst_n, .push, .din(cmd_in), .pop, .dout(cmd_out), .qstat);
	mhkv_back u_back (.clk, .arst_n, .cmd(cmd_out), .qstat, .pop, .m_tvalid, .m_tready,
		.m_tuser, .m_tdata);
endmodule

// ===== verif/modulo_hash_key_value_table_tb.sv =====
// Self-checking testbench for the modulo hash key-value table: random and directed requests.
`timescale 1ns / 100ps
module modulo_hash_key_value_table_tb;

	typedef struct packed {
		mhkv_pkg::req_t req;
		logic [31:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		mhkv_pkg::status_t status;
		logic [31:0] found_value;
	} answer_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [2:0] m_tuser;
	logic s_tready_seen;

	request_t pending_requests[$];
	answer_t expected_answers[$];
	logic table_valid[mhkv_pkg::TOTAL_SLOTS];
	logic [31:0] table_key[mhkv_pkg::TOTAL_SLOTS];
	logic [31:0] table_value[mhkv_pkg::TOTAL_SLOTS];
	int errors;
	int requests_sent;
	int answers_seen;
	int status_count[7];
	int sink_hold;
	int source_hold;
	bit calm;
	bit sender_paused;
	bit holding;

	modulo_hash_key_value_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int base;
		int hit;
		int free_idx;
		a.found_value = '0;
		base = (r.key % mhkv_pkg::NUM_BUCKETS) * mhkv_pkg::SLOTS_PER_BUCKET;
		hit = -1;
		free_idx = -1;
		for (int s = 0; s < mhkv_pkg::SLOTS_PER_BUCKET; s++) begin
			if (table_valid[base+s] && table_key[base+s] == r.key && hit < 0)
				hit = base + s;
			if (!table_valid[base+s] && free_idx < 0)
				free_idx = base + s;
		end
		case (r.req)
			mhkv_pkg::REQ_INSERT: begin
				if (hit >= 0) begin
					table_value[hit] = r.value;
					a.status = mhkv_pkg::ST_UPDATED;
				end else if (free_idx >= 0) begin
					table_valid[free_idx] = 1'b1;
					table_key[free_idx] = r.key;
					table_value[free_idx] = r.value;
					a.status = mhkv_pkg::ST_INSERTED;
				end else begin
					a.status = mhkv_pkg::ST_BUCKET_FULL;
				end
			end
			mhkv_pkg::REQ_REMOVE: begin
				if (hit >= 0) begin
					table_valid[hit] = 1'b0;
					a.status = mhkv_pkg::ST_REMOVED;
				end else begin
					a.status = mhkv_pkg::ST_NOT_FOUND;
				end
			end
			mhkv_pkg::REQ_SEARCH: begin
				if (hit >= 0) begin
					a.found_value = table_value[hit];
					a.status = mhkv_pkg::ST_FOUND;
				end else begin
					a.status = mhkv_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				for (int i = 0; i < mhkv_pkg::TOTAL_SLOTS; i++)
					table_valid[i] = 1'b0;
				a.status = mhkv_pkg::ST_CLEARED;
			end
		endcase
		return a;
	endfunction

	function automatic logic [31:0] pick_key(logic [31:0] keys[$]);
		if (keys.size() > 0 && $urandom_range(0, 3) != 0)
			return keys[$urandom_range(0, keys.size() - 1)];
		return $urandom;
	endfunction

	task automatic push_request(mhkv_pkg::req_t q, logic [31:0] k, logic [31:0] v);
		request_t r;
		r.req = q;
		r.key = k;
		r.value = v;
		pending_requests.push_back(r);
	endtask

	always @(negedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			source_hold <= 0;
		end else begin
			if (s_tvalid && s_tready_seen) begin
				requests_sent <= requests_sent + 1;
			end
			if (s_tvalid && !s_tready_seen) begin
				// Keep offering the same request.
			end else if (source_hold > 0) begin
				s_tvalid <= 1'b0;
				source_hold <= source_hold - 1;
			end else if (!sender_paused && pending_requests.size() > 0
					&& (calm || $urandom_range(0, 5) != 0)) begin
				r = pending_requests.pop_front();
				expected_answers.push_back(apply_request(r));
				s_tvalid <= 1'b1;
				s_tdata <= {r.value, r.key};
				s_tuser <= r.req;
			end else begin
				s_tvalid <= 1'b0;
				if (!calm && pending_requests.size() > 0)
					source_hold <= $urandom_range(0, 4);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s_tready_seen <= 1'b0;
		else
			s_tready_seen <= s_tready;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold <= 0;
		end else if (holding) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			m_tready <= 1'b0;
			sink_hold <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen <= answers_seen + 1;
			if (m_tuser < 7)
				status_count[m_tuser] <= status_count[m_tuser] + 1;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result status %0d value %h", $time, m_tuser, m_tdata);
				errors <= errors + 1;
			end else begin
				want = expected_answers.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.found_value) begin
					$display("%0t: expected status %0d value %h, got status %0d value %h",
						$time, want.status, want.found_value, m_tuser, m_tdata);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		logic [31:0] keys[$];
		logic [31:0] k;
		int pick;
		int bucket;
		arst_n = 1'b0;
		errors = 0;
		requests_sent = 0;
		answers_seen = 0;
		calm = 1'b0;
		sender_paused = 1'b0;
		holding = 1'b0;
		foreach (status_count[i])
			status_count[i] = 0;
		for (int i = 0; i < mhkv_pkg::TOTAL_SLOTS; i++) begin
			table_valid[i] = 1'b0;
			table_key[i] = '0;
			table_value[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, extremes, fill one bucket past full, update, remove, clear.
		push_request(mhkv_pkg::REQ_SEARCH, 32'h0, 32'h0);
		push_request(mhkv_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
		push_request(mhkv_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_request(mhkv_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 32'h0);
		for (int i = 0; i < mhkv_pkg::SLOTS_PER_BUCKET + 1; i++)
			push_request(mhkv_pkg::REQ_INSERT, i * mhkv_pkg::NUM_BUCKETS, 32'hA000_0000 + i);
		push_request(mhkv_pkg::REQ_INSERT, 32'h0, 32'h5555_5555);
		push_request(mhkv_pkg::REQ_SEARCH, 32'h0, 32'hFFFF_FFFF);
		push_request(mhkv_pkg::REQ_REMOVE, 3 * mhkv_pkg::NUM_BUCKETS, 32'h0);
		push_request(mhkv_pkg::REQ_INSERT, 40 * mhkv_pkg::NUM_BUCKETS, 32'h1234_5678);
		push_request(mhkv_pkg::REQ_SEARCH, 40 * mhkv_pkg::NUM_BUCKETS, 32'h0);
		push_request(mhkv_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_request(mhkv_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 32'h0);
		push_request(mhkv_pkg::REQ_INSERT, 32'h0, 32'h0);
		push_request(mhkv_pkg::REQ_SEARCH, 32'h0, 32'h0);

		// Long receiver hold-off so the block backs up its input.
		wait (pending_requests.size() == 0);
		holding = 1'b1;
		for (int i = 0; i < 12; i++)
			push_request(mhkv_pkg::REQ_INSERT, $urandom, $urandom);
		repeat (200) @(posedge clk);
		holding = 1'b0;

		// Sender waits until the table has answered everything.
		wait (pending_requests.size() == 0);
		sender_paused = 1'b1;
		wait (expected_answers.size() == 0);
		@(negedge clk);
		sender_paused = 1'b0;

		// Random requests; keys often reused and packed into few buckets.
		for (int n = 0; n < 1420; n++) begin
			if (n == 1250)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			bucket = $urandom_range(0, 3);
			if ($urandom_range(0, 1) == 0)
				k = ($urandom_range(0, 15) * mhkv_pkg::NUM_BUCKETS) + bucket;
			else
				k = pick_key(keys);
			if (pick < 45) begin
				push_request(mhkv_pkg::REQ_INSERT, k, $urandom);
				if (keys.size() < 64)
					keys.push_back(k);
			end else if (pick < 65) begin
				push_request(mhkv_pkg::REQ_REMOVE, k, $urandom);
			end else if (pick < 97) begin
				push_request(mhkv_pkg::REQ_SEARCH, k, $urandom);
			end else begin
				push_request(mhkv_pkg::REQ_CLEAR, $urandom, $urandom);
			end
			if (pending_requests.size() > 16)
				wait (pending_requests.size() <= 8);
		end
		wait (pending_requests.size() == 0 && expected_answers.size() == 0);
		repeat (40) @(posedge clk);
		$display("Sent %0d requests, covered %0d results: inserted %0d, updated %0d,",
			requests_sent, answers_seen, status_count[0], status_count[1]);
		$display("removed %0d, found %0d, not found %0d, bucket full %0d, cleared %0d.",
			status_count[2], status_count[3], status_count[4], status_count[5],
			status_count[6]);
		if (errors == 0)
			$display("modulo_hash_key_value_table_tb: done, clean");
		else
			$display("modulo_hash_key_value_table_tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("modulo_hash_key_value_table_tb: done, errors");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mhkv_pkg.sv
hw/rtl/mhkv_front.sv
hw/rtl/mhkv_queue.sv
hw/rtl/mhkv_back.sv
hw/rtl/modulo_hash_key_value_table.sv
verif/modulo_hash_key_value_table_tb.sv
